// ===== rtl/core/rcenc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcenc_pkg
// Shared types and constants of the carry-less range encoder: field widths,
// register reset values and the command/status bundle between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rcenc_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned FreqWidth   = 16;
   localparam int unsigned TotalWidth  = 17;
   localparam int unsigned CountWidth  = 25;
   localparam int unsigned IndexWidth  = 24;
   localparam int unsigned CapWidth    = 24;
   localparam int unsigned ThrWidth    = 5;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned StepWidth   = 5;
   localparam int unsigned EmitWidth   = 2;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [WordWidth-1:0]  TopValue      = 32'h0100_0000;
   localparam logic [WordWidth-1:0]  RangeReset    = 32'hFFFF_FFFF;
   localparam logic [CountWidth-1:0] CountMax      = 25'h1FF_FFFF;
   localparam logic [CapWidth-1:0]   CapReset      = 24'hFF_FFFF;
   localparam logic [ThrWidth-1:0]   ThrReset      = 5'd16;
   localparam logic [ThrWidth-1:0]   ThrMin        = 5'd8;
   localparam logic [ThrWidth-1:0]   ThrMax        = 5'd24;
   localparam logic [StepWidth-1:0]  LastDivStep   = 5'd31;
   localparam logic [EmitWidth-1:0]  LastEmit      = 2'd3;

   // item kinds
   localparam logic KindEncode = 1'b0;
   localparam logic KindFlush  = 1'b1;

   // register index, taken from the word address
   localparam logic [0:0] CsrIdxCapacity  = 1'b0;
   localparam logic [0:0] CsrIdxThreshold = 1'b1;

   typedef struct packed {
      logic load;      // capture request fields, seed the divider
      logic div_step;  // one quotient bit
      logic mult;      // range and cum products
      logic add_low;   // low += cum * q
      logic emit;      // send top byte of low, shift
      logic flush;     // emit without touching range
      logic last;      // final beat of this item
   } cmd_type;

   typedef struct packed {
      logic out_free;  // output register can take a beat this cycle
      logic cond;      // renormalisation wanted on the current interval
      logic next_cond; // renormalisation wanted after the shift in progress
   } status_type;

endpackage

// ===== rtl/core/rcenc_csr.sv =====
// ----------------------------------------------------------------------------
// rcenc_csr
// APB-style configuration registers: output capacity and log2 of the
// bottom range threshold.
// ----------------------------------------------------------------------------
module rcenc_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [rcenc_pkg::CsrAddrWidth-1:0]     paddr,
   input  logic [rcenc_pkg::CsrDataWidth-1:0]     pwdata,
   output logic [rcenc_pkg::CsrDataWidth-1:0]     prdata,
   output logic                                   pready,
   output logic [rcenc_pkg::CapWidth-1:0]         capacity,
   output logic [rcenc_pkg::ThrWidth-1:0]         threshold_log2
);

   logic [rcenc_pkg::CapWidth-1:0] capacity_ff;
   logic [rcenc_pkg::ThrWidth-1:0] threshold_ff;
   logic                           write_en;

   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= rcenc_pkg::CapReset;
         threshold_ff <= rcenc_pkg::ThrReset;
      end else if (write_en) begin
         unique case (paddr[2])
            rcenc_pkg::CsrIdxCapacity: begin
               capacity_ff <= pwdata[rcenc_pkg::CapWidth-1:0];
            end
            rcenc_pkg::CsrIdxThreshold: begin
               threshold_ff <= pwdata[rcenc_pkg::ThrWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         rcenc_pkg::CsrIdxCapacity: begin
            prdata = {8'd0, capacity_ff};
         end
         rcenc_pkg::CsrIdxThreshold: begin
            prdata = {27'd0, threshold_ff};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign capacity       = capacity_ff;
   assign threshold_log2 = threshold_ff;

endmodule

// ===== rtl/core/rcenc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcenc_ctrl
// Sequencer of the encoder: input handshake, division step count,
// product and add phases, renormalisation and flush beat count.
// ----------------------------------------------------------------------------
module rcenc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_kind,
   output logic                   req_stall,
   input  rcenc_pkg::status_type  status,
   output rcenc_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MULT,
      ST_ADD,
      ST_RENORM,
      ST_FLUSH
   } state_type;

   state_type                        state_ff;
   logic [rcenc_pkg::StepWidth-1:0]  step_cnt_ff;
   logic [rcenc_pkg::EmitWidth-1:0]  emit_cnt_ff;

   assign req_stall = (state_ff != ST_IDLE) || reset;

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.mult     = (state_ff == ST_MULT);
      cmd.add_low  = (state_ff == ST_ADD);
      if (state_ff == ST_RENORM) begin
         cmd.emit = status.cond && status.out_free;
         cmd.last = (emit_cnt_ff == rcenc_pkg::LastEmit) || !status.next_cond;
      end else if (state_ff == ST_FLUSH) begin
         cmd.emit  = status.out_free;
         cmd.flush = 1'b1;
         cmd.last  = (emit_cnt_ff == rcenc_pkg::LastEmit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_cnt_ff <= '0;
         emit_cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               step_cnt_ff <= '0;
               emit_cnt_ff <= '0;
               if (req_valid) begin
                  state_ff <= (req_kind == rcenc_pkg::KindFlush) ? ST_FLUSH : ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               step_cnt_ff <= step_cnt_ff + 1'b1;
               if (step_cnt_ff == rcenc_pkg::LastDivStep) begin
                  state_ff <= ST_MULT;
               end
            end
            ST_MULT: begin
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               state_ff <= ST_RENORM;
            end
            ST_RENORM: begin
               if (!status.cond) begin
                  // nothing to send for this item
                  state_ff <= ST_IDLE;
               end else if (cmd.emit) begin
                  emit_cnt_ff <= emit_cnt_ff + 1'b1;
                  if (cmd.last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_FLUSH: begin
               if (cmd.emit) begin
                  emit_cnt_ff <= emit_cnt_ff + 1'b1;
                  if (cmd.last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/rcenc_datapath.sv =====
// ----------------------------------------------------------------------------
// rcenc_datapath
// Interval registers, restoring divider, products, renormalisation logic,
// byte counter and the output register of the result channel.
// ----------------------------------------------------------------------------
module rcenc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rcenc_pkg::cmd_type                   cmd,
   output rcenc_pkg::status_type                status,
   input  logic [rcenc_pkg::FreqWidth-1:0]      req_cum_base,
   input  logic [rcenc_pkg::FreqWidth-1:0]      req_sym_freq,
   input  logic [rcenc_pkg::TotalWidth-1:0]     req_total_freq,
   input  logic [rcenc_pkg::CapWidth-1:0]       capacity,
   input  logic [rcenc_pkg::ThrWidth-1:0]       threshold_log2,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rcenc_pkg::ByteWidth-1:0]      rsp_out_byte,
   output logic                                 rsp_stored,
   output logic [rcenc_pkg::IndexWidth-1:0]     rsp_byte_index,
   output logic                                 rsp_last_of_run
);

   localparam int unsigned W = rcenc_pkg::WordWidth;

   logic [W-1:0]                          low_ff, range_ff;
   logic [rcenc_pkg::CountWidth-1:0]      count_ff;
   logic [rcenc_pkg::FreqWidth-1:0]       cum_ff, freq_ff;
   logic [rcenc_pkg::TotalWidth-1:0]      total_ff;
   logic [W-1:0]                          quo_ff, cq_ff;
   logic [rcenc_pkg::TotalWidth-1:0]      rem_ff;
   logic [rcenc_pkg::ByteWidth-1:0]       out_byte_ff;
   logic                                  stored_ff, last_ff, rsp_valid_ff;
   logic [rcenc_pkg::IndexWidth-1:0]      index_ff;

   logic [rcenc_pkg::TotalWidth:0]        rem_shift, rem_diff;
   logic                                  quo_bit;
   logic [rcenc_pkg::ThrWidth-1:0]        thr_clamped;
   logic [W-1:0]                          bot;
   logic [W-1:0]                          sum, diff, range_p, sum_p, diff_next, range_next;
   logic                                  narrow, clip;
   logic [23:0]                           low_neg;
   logic [rcenc_pkg::IndexWidth-1:0]      index_now;

   // restoring division, one quotient bit a cycle
   assign rem_shift = {rem_ff, quo_ff[W-1]};
   assign rem_diff  = rem_shift - {1'b0, total_ff};
   assign quo_bit   = (rem_shift >= {1'b0, total_ff});

   always_comb begin
      if (threshold_log2 < rcenc_pkg::ThrMin) begin
         thr_clamped = rcenc_pkg::ThrMin;
      end else if (threshold_log2 > rcenc_pkg::ThrMax) begin
         thr_clamped = rcenc_pkg::ThrMax;
      end else begin
         thr_clamped = threshold_log2;
      end
   end
   assign bot = W'(1) << thr_clamped;

   // renormalisation test now and after the pending shift
   assign sum     = low_ff + range_ff;
   assign diff    = low_ff ^ sum;
   assign narrow  = range_ff < bot;
   assign clip    = narrow && (diff >= rcenc_pkg::TopValue);
   assign low_neg = ~low_ff[23:0] + 24'd1;
   assign range_p = clip ? {8'd0, low_neg} : range_ff;

   // low plus the clipped range is low rounded up to the next 2^24 boundary
   always_comb begin
      if (!clip) begin
         sum_p = sum;
      end else if (low_ff[23:0] == 24'd0) begin
         sum_p = low_ff;
      end else begin
         sum_p = {low_ff[31:24] + 8'd1, 24'd0};
      end
   end
   assign diff_next  = (low_ff ^ sum_p) << 8;
   assign range_next = range_p << 8;

   assign status.cond      = (diff < rcenc_pkg::TopValue) || narrow;
   assign status.next_cond = (diff_next < rcenc_pkg::TopValue) || (range_next < bot);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign index_now = count_ff[rcenc_pkg::CountWidth-1] ? '1
                    : count_ff[rcenc_pkg::IndexWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= '0;
         range_ff     <= rcenc_pkg::RangeReset;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.add_low) begin
            low_ff <= low_ff + cq_ff;
         end
         if (cmd.mult) begin
            range_ff <= quo_ff * W'(freq_ff);
         end
         if (cmd.emit) begin
            low_ff <= low_ff << 8;
            if (!cmd.flush) begin
               range_ff <= range_next;
            end
            if (count_ff != rcenc_pkg::CountMax) begin
               count_ff <= count_ff + 1'b1;
            end
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cum_ff   <= req_cum_base;
         freq_ff  <= (req_sym_freq == '0) ? rcenc_pkg::FreqWidth'(1) : req_sym_freq;
         total_ff <= (req_total_freq == '0) ? rcenc_pkg::TotalWidth'(1) : req_total_freq;
         quo_ff   <= range_ff;
         rem_ff   <= '0;
      end
      if (cmd.div_step) begin
         quo_ff <= {quo_ff[W-2:0], quo_bit};
         rem_ff <= quo_bit ? rem_diff[rcenc_pkg::TotalWidth-1:0]
                           : rem_shift[rcenc_pkg::TotalWidth-1:0];
      end
      if (cmd.mult) begin
         cq_ff <= quo_ff * W'(cum_ff);
      end
      if (cmd.emit) begin
         out_byte_ff <= low_ff[W-1 -: rcenc_pkg::ByteWidth];
         stored_ff   <= (count_ff < {1'b0, capacity});
         index_ff    <= index_now;
         last_ff     <= cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_stored      = stored_ff;
   assign rsp_byte_index  = index_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== rtl/core/range_coder_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// range_coder_encoder_unit
// Carry-less range encoder producing one code byte per result beat.
//
// Input channel req_*: kind 0 encodes the interval (cum_base, sym_freq,
// total_freq), kind 1 flushes the four bytes of low. Result channel rsp_*:
// one beat per emitted byte with its stream position, a stored flag
// against the capacity register and a marker on the final byte of the item.
// Configuration through the APB-style port: capacity at 0x0, log2 of the
// bottom threshold at 0x4.
// An encode item passes through an accept step, the bit-per-cycle
// restoring divider, a product step and an add step, then
// renormalisation, which emits 0 to 4 bytes. A flush is accepted and then
// emits the four bytes of low.
// Only one item is in work at a time; req_stall is low only while idle and
// out of reset, even when a result beat still waits in the output register.
// A stall on rsp holds the output register; the renormalisation step waits
// until the beat is taken. Synchronous reset clears low to 0, range to all
// ones, the byte count and rsp_valid to 0 and the CSRs to their defaults.
// ----------------------------------------------------------------------------
module range_coder_encoder_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [rcenc_pkg::FreqWidth-1:0]      req_cum_base,
   input  logic [rcenc_pkg::FreqWidth-1:0]      req_sym_freq,
   input  logic [rcenc_pkg::TotalWidth-1:0]     req_total_freq,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rcenc_pkg::ByteWidth-1:0]      rsp_out_byte,
   output logic                                 rsp_stored,
   output logic [rcenc_pkg::IndexWidth-1:0]     rsp_byte_index,
   output logic                                 rsp_last_of_run,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rcenc_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [rcenc_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [rcenc_pkg::CsrDataWidth-1:0]   prdata,
   output logic                                 pready
);

   rcenc_pkg::cmd_type              cmd;
   rcenc_pkg::status_type           status;
   logic [rcenc_pkg::CapWidth-1:0]  capacity;
   logic [rcenc_pkg::ThrWidth-1:0]  threshold_log2;

   rcenc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .capacity       (capacity),
      .threshold_log2 (threshold_log2)
   );

   rcenc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rcenc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_cum_base    (req_cum_base),
      .req_sym_freq    (req_sym_freq),
      .req_total_freq  (req_total_freq),
      .capacity        (capacity),
      .threshold_log2  (threshold_log2),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_stored      (rsp_stored),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
